// ===== rtl/websocket_frame_deframer_core_assert.svh =====
// assertion macros for the deframer core
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define WSFD_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("deframer assertion failed");
`define WSFD_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("deframer assertion failed");
`else
`define WSFD_ASSERT_NOW(lbl, clk, rst, pre, post)
`define WSFD_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

// ===== rtl/wsfd_pkg.sv =====
package wsfd_pkg;

   localparam int unsigned LEN_W = 63;

   typedef enum logic [1:0] {
      EV_PAYLOAD = 2'd0,
      EV_EMPTY   = 2'd1,
      EV_ERROR   = 2'd2
   } event_type;

   typedef enum logic [2:0] {
      ERR_RSV        = 3'd0,
      ERR_UNMASKED   = 3'd1,
      ERR_OPCODE     = 3'd2,
      ERR_FRAG_CTRL  = 3'd3,
      ERR_CTRL_LONG  = 3'd4,
      ERR_TOO_LARGE  = 3'd5,
      ERR_LEN64_MSB  = 3'd6
   } err_type;

   localparam logic [6:0] LEN7_MAX_SHORT = 7'd125;
   localparam logic [6:0] LEN7_EXT16     = 7'd126;
   localparam logic [3:0] OP_CONT        = 4'h0;
   localparam logic [3:0] OP_BINARY      = 4'h2;
   localparam logic [3:0] OP_CLOSE       = 4'h8;
   localparam logic [3:0] OP_PONG        = 4'hA;

endpackage

// ===== rtl/websocket_frame_deframer_core.sv =====
// WebSocket client-to-server frame deframer.
// Input channel req_*: one stream byte per word, valid/ready handshake.
// Result channel rsp_*: zero or one word per input byte: an unmasked
// payload byte (rsp_frame_last marks the final one), an empty frame end on
// the last masking key byte, or a single protocol error.
// csr_wr_en/csr_wr_data write the payload size limit, zero means no limit;
// write only while the block is idle.
// rsp_valid rises in the cycle after a byte is taken. One byte is accepted
// every cycle unless the result slot stalls: the header parse, the 63-bit
// limit compare and the payload down-counter all sit between the state
// registers and the result register. The result register is a single slot;
// req_ready is high when it is empty or being taken in the same cycle, so a
// stalled receiver backs up the input after one word and nothing is dropped.
// After an error the block keeps accepting bytes but produces nothing until
// reset. Synchronous reset returns to the first header byte, clears the
// limit and empties the result slot.
module websocket_frame_deframer_core
   import wsfd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_event_res,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_frame_last,
   output logic             rsp_frame_fin,
   output logic [3:0]       rsp_frame_opcode,
   output logic [2:0]       rsp_error_code,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      PH_HDR0, PH_HDR1, PH_LEN16, PH_LEN64, PH_KEY, PH_PAYLOAD
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic             fin_ff, fin_in;
   logic [3:0]       opcode_ff, opcode_in;
   logic             rsv_ff, rsv_in;
   logic [31:0]      key_ff, key_in;
   logic [63:0]      len_ff, len_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [1:0]       kidx_ff, kidx_in;
   logic             error_ff, error_in;
   logic [LEN_W-1:0] max_ff;

   logic             rsp_valid_ff;
   event_type        rsp_event_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff, rsp_fin_ff;
   logic [3:0]       rsp_opcode_ff;
   err_type          rsp_code_ff;

   logic             accept, produce;
   event_type        ev;
   logic [7:0]       out_byte;
   logic             out_last;
   err_type          code;

   logic [7:0]       b;
   logic [6:0]       len7;
   logic             ctl, op_ok, limit_on, too7, too_ext;
   logic [63:0]      len_acc;
   logic [31:0]      key_acc;
   logic [7:0]       kb;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign b         = req_rx_byte;
   assign len7      = b[6:0];
   assign ctl       = opcode_ff[3];
   assign limit_on  = max_ff != '0;
   assign too7      = limit_on && ({{(LEN_W-7){1'b0}}, len7} > max_ff);
   assign len_acc   = {len_ff[55:0], b};
   assign too_ext   = limit_on && (len_acc[LEN_W-1:0] > max_ff);
   assign key_acc   = {key_ff[23:0], b};

   always_comb begin
      op_ok = opcode_ff inside {[OP_CONT:OP_BINARY], [OP_CLOSE:OP_PONG]};
      case (kidx_ff)
         2'd0:    kb = key_ff[31:24];
         2'd1:    kb = key_ff[23:16];
         2'd2:    kb = key_ff[15:8];
         default: kb = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      rsv_in    = rsv_ff;
      key_in    = key_ff;
      len_in    = len_ff;
      remain_in = remain_ff;
      kidx_in   = kidx_ff;
      error_in  = error_ff;
      produce   = 1'b0;
      ev        = EV_PAYLOAD;
      out_byte  = '0;
      out_last  = 1'b0;
      code      = ERR_RSV;
      if (accept && !error_ff) begin
         case (phase_ff)
            PH_HDR0: begin
               fin_in    = b[7];
               opcode_in = b[3:0];
               rsv_in    = b[6:4] != 3'd0;
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               cnt_in = '0;
               if (rsv_ff) begin
                  produce = 1'b1;
                  code    = ERR_RSV;
               end else if (!b[7]) begin
                  produce = 1'b1;
                  code    = ERR_UNMASKED;
               end else if (!op_ok) begin
                  produce = 1'b1;
                  code    = ERR_OPCODE;
               end else if (ctl && !fin_ff) begin
                  produce = 1'b1;
                  code    = ERR_FRAG_CTRL;
               end else if (ctl && len7 > LEN7_MAX_SHORT) begin
                  produce = 1'b1;
                  code    = ERR_CTRL_LONG;
               end else if (len7 <= LEN7_MAX_SHORT) begin
                  len_in = {57'd0, len7};
                  if (too7) begin
                     produce = 1'b1;
                     code    = ERR_TOO_LARGE;
                  end else begin
                     key_in   = '0;
                     phase_in = PH_KEY;
                  end
               end else begin
                  len_in   = '0;
                  phase_in = (len7 == LEN7_EXT16) ? PH_LEN16 : PH_LEN64;
               end
               if (produce) begin
                  ev       = EV_ERROR;
                  error_in = 1'b1;
               end
            end
            PH_LEN16, PH_LEN64: begin
               len_in = len_acc;
               cnt_in = cnt_ff + 3'd1;
               if ((phase_ff == PH_LEN16 && cnt_ff == 3'd1) ||
                   (phase_ff == PH_LEN64 && cnt_ff == 3'd7)) begin
                  len_in = {1'b0, len_acc[LEN_W-1:0]};
                  if (phase_ff == PH_LEN64 && len_acc[63]) begin
                     produce = 1'b1;
                     code    = ERR_LEN64_MSB;
                  end else if (too_ext) begin
                     produce = 1'b1;
                     code    = ERR_TOO_LARGE;
                  end else begin
                     cnt_in   = '0;
                     key_in   = '0;
                     phase_in = PH_KEY;
                  end
                  if (produce) begin
                     ev       = EV_ERROR;
                     error_in = 1'b1;
                  end
               end
            end
            PH_KEY: begin
               key_in = key_acc;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  cnt_in    = '0;
                  kidx_in   = '0;
                  remain_in = len_ff[LEN_W-1:0];
                  if (len_ff == '0) begin
                     phase_in = PH_HDR0;
                     produce  = 1'b1;
                     ev       = EV_EMPTY;
                     out_last = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               produce   = 1'b1;
               ev        = EV_PAYLOAD;
               out_byte  = b ^ kb;
               kidx_in   = kidx_ff + 2'd1;
               remain_in = remain_ff - {{(LEN_W-1){1'b0}}, 1'b1};
               out_last  = remain_ff == {{(LEN_W-1){1'b0}}, 1'b1};
               if (out_last) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         cnt_ff       <= '0;
         fin_ff       <= 1'b0;
         opcode_ff    <= '0;
         rsv_ff       <= 1'b0;
         key_ff       <= '0;
         len_ff       <= '0;
         remain_ff    <= '0;
         kidx_ff      <= '0;
         error_ff     <= 1'b0;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         rsv_ff    <= rsv_in;
         key_ff    <= key_in;
         len_ff    <= len_in;
         remain_ff <= remain_in;
         kidx_ff   <= kidx_in;
         error_ff  <= error_in;
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
         // result slot payload, loaded with the fin/opcode of the current frame
         if (produce) begin
            rsp_valid_ff  <= 1'b1;
            rsp_event_ff  <= ev;
            rsp_byte_ff   <= out_byte;
            rsp_last_ff   <= out_last;
            rsp_fin_ff    <= fin_ff;
            rsp_opcode_ff <= opcode_ff;
            rsp_code_ff   <= (ev == EV_ERROR) ? code : ERR_RSV;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = rsp_event_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_frame_last   = rsp_last_ff;
   assign rsp_frame_fin    = rsp_fin_ff;
   assign rsp_frame_opcode = rsp_opcode_ff;
   assign rsp_error_code   = rsp_code_ff;

`include "websocket_frame_deframer_core_assert.svh"

   // once sticky error is set the slot can only hold the error word
   `WSFD_ASSERT_NOW(a_err_last, clock, reset, error_ff && rsp_valid_ff, rsp_event_ff == EV_ERROR)
   // payload phase always has bytes left to count
   `WSFD_ASSERT_NOW(a_remain, clock, reset, phase_ff == PH_PAYLOAD, remain_ff != '0)
   // key phase never counts past four bytes
   `WSFD_ASSERT_NOW(a_key_cnt, clock, reset, phase_ff == PH_KEY, cnt_ff < 3'd4)
   // an error byte sets the sticky flag and leaves a word waiting
   `WSFD_ASSERT_NEXT(a_err_set, clock, reset, produce && ev == EV_ERROR, error_ff && rsp_valid_ff)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench
   import wsfd_pkg::*;
();

   localparam logic [3:0] OP_TEXT    = 4'h1;
   localparam logic [3:0] OP_PING    = 4'h9;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;
   localparam int unsigned SETTLE_CYCLES = 4;

   typedef enum logic [2:0] {
      AT_HDR0, AT_HDR1, AT_LEN16, AT_LEN64, AT_KEY, AT_PAYLOAD
   } parse_pos_type;

   typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_type;

   typedef struct packed {
      event_type  ev;
      logic [7:0] data;
      logic       last;
      logic       fin;
      logic [3:0] opcode;
      err_type    code;
   } deframe_word_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [7:0]       req_rx_byte;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [1:0]       rsp_event_res;
   logic [7:0]       rsp_payload_byte;
   logic             rsp_frame_last;
   logic             rsp_frame_fin;
   logic [3:0]       rsp_frame_opcode;
   logic [2:0]       rsp_error_code;
   logic             csr_wr_en;
   logic [LEN_W-1:0] csr_wr_data;

   // deframer shadow state
   parse_pos_type    pos        = AT_HDR0;
   logic             hdr_fin    = 1'b0;
   logic [3:0]       hdr_op     = '0;
   logic             hdr_rsv    = 1'b0;
   int               len_bytes  = 0;
   logic [63:0]      frame_len  = '0;
   logic [31:0]      key_word   = '0;
   logic [62:0]      bytes_done = '0;
   logic             sticky_err = 1'b0;
   logic [62:0]      size_limit = '0;

   deframe_word_type expected_words[$];

   int unsigned      send_idle_pct  = 0;
   int unsigned      recv_stall_pct = 0;
   int unsigned      hold_len       = 0;
   int unsigned      hold_seq       = 0;
   int unsigned      mismatches     = 0;
   int unsigned      bytes_taken    = 0;
   int unsigned      words_checked  = 0;
   int unsigned      frames_sent    = 0;
   err_type          err_case       = ERR_RSV;

   websocket_frame_deframer_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_fin    (rsp_frame_fin),
      .rsp_frame_opcode (rsp_frame_opcode),
      .rsp_error_code   (rsp_error_code),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("websocket_frame_deframer_core regression: fail");
      $finish;
   end

   function automatic void push_word(input event_type ev, input logic [7:0] data,
                                     input logic last, input err_type code);
      deframe_word_type w;
      w.ev     = ev;
      w.data   = data;
      w.last   = last;
      w.fin    = hdr_fin;
      w.opcode = hdr_op;
      w.code   = code;
      expected_words.insert(expected_words.size(), w);
   endfunction

   function automatic void flag_error(input err_type code);
      sticky_err = 1'b1;
      push_word(EV_ERROR, 8'h00, 1'b0, code);
   endfunction

   function automatic logic over_limit();
      return size_limit != '0 && frame_len[62:0] > size_limit;
   endfunction

   // ERR_RSV doubles as the all-zero code field outside error words
   function automatic void deframe_byte(input logic [7:0] b);
      logic [6:0] len7;
      logic       ctrl;
      logic [7:0] key_byte;
      if (sticky_err)
         return;
      case (pos)
         AT_HDR0: begin
            hdr_fin = b[7];
            hdr_op  = b[3:0];
            hdr_rsv = |b[6:4];
            pos     = AT_HDR1;
         end
         AT_HDR1: begin
            len7 = b[6:0];
            ctrl = hdr_op >= OP_CLOSE;
            if (hdr_rsv)
               flag_error(ERR_RSV);
            else if (!b[7])
               flag_error(ERR_UNMASKED);
            else if (hdr_op > OP_BINARY && (hdr_op < OP_CLOSE || hdr_op > OP_PONG))
               flag_error(ERR_OPCODE);
            else if (ctrl && !hdr_fin)
               flag_error(ERR_FRAG_CTRL);
            else if (ctrl && len7 > LEN7_MAX_SHORT)
               flag_error(ERR_CTRL_LONG);
            else begin
               len_bytes = 0;
               if (len7 <= LEN7_MAX_SHORT) begin
                  frame_len = 64'(len7);
                  if (over_limit())
                     flag_error(ERR_TOO_LARGE);
                  else begin
                     key_word = '0;
                     pos      = AT_KEY;
                  end
               end else begin
                  frame_len = '0;
                  pos = (len7 == LEN7_EXT16) ? AT_LEN16 : AT_LEN64;
               end
            end
         end
         AT_LEN16, AT_LEN64: begin
            frame_len = {frame_len[55:0], b};
            len_bytes++;
            if (len_bytes == ((pos == AT_LEN16) ? 2 : 8)) begin
               if (pos == AT_LEN64 && frame_len[63])
                  flag_error(ERR_LEN64_MSB);
               else begin
                  frame_len[63] = 1'b0;
                  if (over_limit())
                     flag_error(ERR_TOO_LARGE);
                  else begin
                     len_bytes = 0;
                     key_word  = '0;
                     pos       = AT_KEY;
                  end
               end
            end
         end
         AT_KEY: begin
            key_word = {key_word[23:0], b};
            len_bytes++;
            if (len_bytes == 4) begin
               len_bytes  = 0;
               bytes_done = '0;
               if (frame_len == '0) begin
                  pos = AT_HDR0;
                  push_word(EV_EMPTY, 8'h00, 1'b1, ERR_RSV);
               end else
                  pos = AT_PAYLOAD;
            end
         end
         AT_PAYLOAD: begin
            key_byte = key_word[8 * (3 - bytes_done[1:0]) +: 8];
            bytes_done++;
            if (bytes_done >= frame_len[62:0])
               pos = AT_HDR0;
            push_word(EV_PAYLOAD, b ^ key_byte, bytes_done >= frame_len[62:0], ERR_RSV);
         end
         default: begin
            pos = AT_HDR0;
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         bytes_taken++;
         deframe_byte(req_rx_byte);
      end
   end

   always @(posedge clock) begin
      deframe_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected: event %0d", rsp_event_res);
            mismatches++;
         end else begin
            want = expected_words[0];
            expected_words.delete(0);
            check_field("event_res", 8'(want.ev), 8'(rsp_event_res));
            check_field("payload_byte", want.data, rsp_payload_byte);
            check_field("frame_last", 8'(want.last), 8'(rsp_frame_last));
            check_field("frame_fin", 8'(want.fin), 8'(rsp_frame_fin));
            check_field("frame_opcode", 8'(want.opcode), 8'(rsp_frame_opcode));
            check_field("error_code", 8'(want.code), 8'(rsp_error_code));
         end
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   initial begin
      int unsigned hold_left;
      int unsigned seen_seq;
      hold_left = 0;
      seen_seq  = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != seen_seq) begin
            seen_seq  = hold_seq;
            hold_left = hold_len;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [62:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      size_limit  = value;
   endtask

   task automatic send_frame(input logic fin, input logic [3:0] op, input logic [62:0] len,
                             input len_form_type form, input logic [31:0] key);
      logic [63:0] ext;
      ext = {1'b0, len};
      send_byte({fin, 3'b000, op});
      case (form)
         LEN_EXT16: begin
            send_byte({1'b1, LEN7_EXT16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         LEN_EXT64: begin
            send_byte({1'b1, LEN7_EXT64});
            for (int i = 7; i >= 0; i--)
               send_byte(ext[8 * i +: 8]);
         end
         // short form
         default: send_byte({1'b1, len[6:0]});
      endcase
      for (int i = 3; i >= 0; i--)
         send_byte(key[8 * i +: 8]);
      for (longint unsigned i = 0; i < len; i++)
         send_byte(8'($urandom));
      frames_sent++;
   endtask

   task automatic send_random_frame();
      logic [3:0]   op;
      logic         fin;
      logic [62:0]  len;
      len_form_type form;
      int unsigned  pick;
      pick = $urandom_range(99);
      if (pick < 50)
         len = 63'($urandom_range(4));
      else if (pick < 80)
         len = 63'($urandom_range(20, 5));
      else if (pick < 92)
         len = 63'($urandom_range(130, 21));
      else
         len = 63'($urandom_range(260, 126));
      case ($urandom_range(5))
         0:       op = OP_CONT;
         1:       op = OP_TEXT;
         2:       op = OP_BINARY;
         3:       op = OP_CLOSE;
         4:       op = OP_PING;
         default: op = OP_PONG;
      endcase
      fin = 1'($urandom_range(1));
      if (op >= OP_CLOSE) begin
         // control frames: final, short length only
         fin = 1'b1;
         if (len > LEN7_MAX_SHORT)
            len = 63'($urandom_range(LEN7_MAX_SHORT));
      end
      if (size_limit != '0 && len > size_limit)
         len = 63'($urandom_range(32'(size_limit)));
      pick = $urandom_range(19);
      if (op >= OP_CLOSE)
         form = LEN_SHORT;
      else if (len > LEN7_MAX_SHORT)
         form = ($urandom_range(3) == 0) ? LEN_EXT64 : LEN_EXT16;
      else
         form = (pick < 17) ? LEN_SHORT : (pick < 19) ? LEN_EXT16 : LEN_EXT64;
      send_frame(fin, op, len, form, $urandom);
   endtask

   task automatic test_directed();
      send_frame(1'b1, OP_TEXT, 63'd0, LEN_SHORT, 32'h0000_0000);
      send_frame(1'b0, OP_BINARY, 63'd1, LEN_SHORT, 32'hFFFF_FFFF);
      // over-long length encoding is still accepted
      send_frame(1'b1, OP_CONT, 63'd3, LEN_EXT16, $urandom);
      send_frame(1'b1, OP_PING, 63'd0, LEN_SHORT, $urandom);
      send_frame(1'b1, OP_PONG, 63'd2, LEN_SHORT, 32'hA5A5_5A5A);
      wait_for_results();
   endtask

   task automatic test_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                               input logic [62:0] limit, input int unsigned n_bytes);
      int unsigned start;
      write_limit(limit);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      start = bytes_taken;
      while (bytes_taken - start < n_bytes)
         send_random_frame();
      wait_for_results();
   endtask

   task automatic test_limit_edges();
      send_idle_pct  = 11;
      recv_stall_pct = 11;
      write_limit(63'd1);
      send_frame(1'b1, OP_TEXT, 63'd1, LEN_SHORT, $urandom);
      send_frame(1'b1, OP_BINARY, 63'd0, LEN_EXT64, $urandom);
      send_frame(1'b0, OP_CONT, 63'd1, LEN_EXT16, $urandom);
      wait_for_results();
      write_limit(63'd126);
      send_frame(1'b1, OP_BINARY, 63'd126, LEN_EXT16, $urandom);
      send_frame(1'b1, OP_CLOSE, 63'd125, LEN_SHORT, $urandom);
      wait_for_results();
   endtask

   task automatic test_backpressure();
      int unsigned start;
      write_limit('0);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_len = 300;
      hold_seq++;
      start = bytes_taken;
      while (bytes_taken - start < 80)
         send_random_frame();
      wait_for_results();
   endtask

   // the error is sticky, so only one kind can be hit per run
   task automatic test_protocol_error();
      logic [3:0]  ctrl_op;
      logic [62:0] limit;
      logic [62:0] len;
      send_idle_pct  = 11;
      recv_stall_pct = 11;
      ctrl_op  = (OP_CLOSE + 4'($urandom_range(2)));
      err_case = err_type'($urandom_range(6));
      case (err_case)
         ERR_RSV: begin
            send_byte({1'b1, 3'($urandom_range(7, 1)), OP_TEXT});
            send_byte({1'b1, 7'd5});
         end
         ERR_UNMASKED: begin
            send_byte({1'b1, 3'b000, OP_BINARY});
            send_byte({1'b0, 7'($urandom_range(127))});
         end
         ERR_OPCODE: begin
            send_byte({1'($urandom_range(1)), 3'b000,
                       ($urandom_range(1) != 0) ? 4'($urandom_range(7, 3))
                                                : 4'($urandom_range(15, 11))});
            send_byte({1'b1, 7'd0});
         end
         ERR_FRAG_CTRL: begin
            send_byte({1'b0, 3'b000, ctrl_op});
            send_byte({1'b1, 7'd0});
         end
         ERR_CTRL_LONG: begin
            send_byte({1'b1, 3'b000, ctrl_op});
            send_byte({1'b1, ($urandom_range(1) != 0) ? LEN7_EXT16 : LEN7_EXT64});
         end
         ERR_TOO_LARGE: begin
            limit = 63'($urandom_range(100, 1));
            write_limit(limit);
            len = limit + 63'(1 + $urandom_range(30));
            send_frame(1'b1, OP_BINARY, len,
                       (len > LEN7_MAX_SHORT) ? LEN_EXT16 : LEN_SHORT, $urandom);
         end
         default: begin
            send_byte({1'b1, 3'b000, OP_BINARY});
            send_byte({1'b1, LEN7_EXT64});
            send_byte(8'h80 | 8'($urandom));
            repeat (7) send_byte(8'($urandom));
         end
      endcase
      // everything after the error is dropped
      repeat (40) send_byte(8'($urandom));
      wait_for_results();
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_traffic(0, 0, {63{1'b1}}, 45);
      test_traffic(88, 0, '0, 45);
      test_traffic(0, 88, 63'($urandom_range(40, 1)), 45);
      test_traffic(11, 11, {31'($urandom), 32'($urandom)}, 45);
      test_limit_edges();
      test_backpressure();
      test_protocol_error();

      $display("covered %0d stream bytes in %0d frames, %0d result words checked",
               bytes_taken, frames_sent, words_checked);
      $display("closing violation exercised: %s", err_case.name());
      if (mismatches == 0)
         $display("websocket_frame_deframer_core regression: pass");
      else
         $display("websocket_frame_deframer_core regression: fail");
      $finish;
   end

endmodule
